// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/core/osc_tsp_pkg.sv
// ----------------------------------------------------------------------------
// OSC title sequence parser package
// Types and byte codes shared by the parser modules.
// ----------------------------------------------------------------------------
package osc_tsp_pkg;

  localparam int unsigned BUF_SIZE_DEF = 1024;

  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_BEL   = 8'h07;
  localparam logic [7:0] BYTE_OSC8  = 8'h9D;
  localparam logic [7:0] BYTE_ST8   = 8'h9C;
  localparam logic [7:0] BYTE_RBRK  = 8'h5D;
  localparam logic [7:0] BYTE_BSLSH = 8'h5C;
  localparam logic [7:0] BYTE_SEMI  = 8'h3B;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_OSC,
    PH_ESC_IN
  } seq_phase_t;

  typedef enum logic [1:0] {
    FLD_DIGITS,
    FLD_TEXT,
    FLD_SKIP
  } fld_phase_t;

  typedef struct packed {
    logic [7:0] title_byte;
    logic       title_end;
    logic [1:0] title_command;
  } title_item_t;

  typedef struct packed {
    logic        p0;
    logic        p1;
    title_item_t i0;
    title_item_t i1;
  } push_t;

endpackage

// File: rtl/core/osc_tsp_outq.sv
// ----------------------------------------------------------------------------
// OSC title result queue
// Four-entry queue that takes up to two result beats per cycle and hands
// out one per cycle on the master stream side while m_tready is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module osc_tsp_outq (
  input  logic                clk,
  input  logic                rst,
  input  osc_tsp_pkg::push_t  push,
  output logic                room,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // [7:0] title_byte
  output logic                m_tlast,
  output logic [1:0]          m_tuser    // [1:0] title_command
);

  osc_tsp_pkg::title_item_t mem [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;
  logic [2:0] cnt_next;
  logic       pop;
  logic [2:0] n_push;

  assign pop      = m_tvalid && m_tready;
  assign n_push   = {2'b00, push.p0} + {2'b00, push.p1};
  assign cnt_next = cnt + n_push - {2'b00, pop};
  assign room     = (cnt <= 3'd2);

  assign m_tvalid = (cnt != 3'd0);
  assign m_tdata  = mem[rp].title_byte;
  assign m_tlast  = mem[rp].title_end;
  assign m_tuser  = mem[rp].title_command;

  always_ff @(posedge clk) begin
    if (push.p0) begin
      mem[wp] <= push.i0;
    end
    if (push.p1) begin
      mem[wp + 2'd1] <= push.i1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + n_push[1:0];
      rp  <= rp + {1'b0, pop};
      cnt <= cnt_next;
    end
  end

  `ASSERT_NEVER(a_q_overflow, clk, rst, cnt > 3'd4, "result queue overflow")
  `ASSERT_CLK(a_q_push_room, clk, rst, push.p0 |-> room, "push without room")
  `ASSERT_CLK(a_q_push_order, clk, rst, push.p1 |-> push.p0, "second push without first")

endmodule

// File: rtl/core/osc_tsp_core.sv
// ----------------------------------------------------------------------------
// OSC title parser core
// Input beat register, sequence state and the per-byte parsing step that
// yields up to three result beats per byte, the third held as a pending end beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module osc_tsp_core #(
  parameter int unsigned BUF_SIZE = osc_tsp_pkg::BUF_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                room,
  output osc_tsp_pkg::push_t  push
);

  localparam int unsigned CW = $clog2(BUF_SIZE);
  localparam logic [CW:0] Lim    = (CW + 1)'(BUF_SIZE - 1);
  localparam logic [CW:0] BufLim = (CW + 1)'(BUF_SIZE);

  typedef struct packed {
    osc_tsp_pkg::fld_phase_t fld;
    logic [1:0]              cmd;
    logic                    digit;
    logic                    zero;
    logic [CW:0]             cnt;
    logic                    emit;
  } stp_t;

  function automatic stp_t store_fn(stp_t s, logic [7:0] b);
    stp_t       r;
    logic [7:0] d;
    r      = s;
    r.emit = 1'b0;
    d      = b - osc_tsp_pkg::BYTE_ZERO;
    if (s.cnt < BufLim) begin
      r.cnt = s.cnt + 1'b1;
    end
    if (s.cnt < Lim) begin
      case (s.fld)
        osc_tsp_pkg::FLD_DIGITS: begin
          if (b >= osc_tsp_pkg::BYTE_ZERO && b <= osc_tsp_pkg::BYTE_NINE) begin
            r.digit = 1'b1;
            if (s.cmd == 2'd0) begin
              r.cmd = (d > 8'd3) ? 2'd3 : d[1:0];
            end else begin
              r.cmd = 2'd3;
            end
          end else if (b == osc_tsp_pkg::BYTE_SEMI && s.digit) begin
            r.fld = osc_tsp_pkg::FLD_TEXT;
          end else begin
            r.fld = osc_tsp_pkg::FLD_SKIP;
          end
        end
        osc_tsp_pkg::FLD_TEXT: begin
          if (!s.zero) begin
            if (b == 8'h00) begin
              r.zero = 1'b1;
            end else if (s.cmd <= 2'd2) begin
              r.emit = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  logic                     c1;
  logic                     in_vld;
  logic [7:0]               in_byte;
  logic                     fire;
  osc_tsp_pkg::seq_phase_t  phase;
  osc_tsp_pkg::seq_phase_t  phase_next;
  osc_tsp_pkg::fld_phase_t  fld;
  logic [1:0]               cmd;
  logic                     digit;
  logic                     zero;
  logic [CW-1:0]            cnt;
  logic                     end_pend;
  logic                     end_pend_next;
  logic [1:0]               pend_cmd;
  stp_t                     st;
  osc_tsp_pkg::title_item_t slot [3];
  logic [1:0]               k;
  logic                     done;

  assign fire     = in_vld && room;
  assign s_tready = !in_vld || fire;

  always_comb begin
    phase_next = phase;
    st         = '{fld: fld, cmd: cmd, digit: digit, zero: zero,
                   cnt: {1'b0, cnt}, emit: 1'b0};
    k          = 2'd0;
    done       = 1'b0;
    for (int i = 0; i < 3; i++) begin
      slot[i] = '0;
    end
    if (end_pend) begin
      slot[0] = '{title_byte: 8'h00, title_end: 1'b1, title_command: pend_cmd};
      k       = 2'd1;
    end
    case (phase)
      osc_tsp_pkg::PH_IDLE: begin
        if (in_byte == osc_tsp_pkg::BYTE_ESC) begin
          phase_next = osc_tsp_pkg::PH_ESC;
        end else if (in_byte == osc_tsp_pkg::BYTE_OSC8 && c1) begin
          phase_next = osc_tsp_pkg::PH_OSC;
        end
      end
      osc_tsp_pkg::PH_ESC: begin
        phase_next = (in_byte == osc_tsp_pkg::BYTE_RBRK) ? osc_tsp_pkg::PH_OSC
                                                         : osc_tsp_pkg::PH_IDLE;
      end
      osc_tsp_pkg::PH_OSC: begin
        if (in_byte == osc_tsp_pkg::BYTE_ESC) begin
          phase_next = osc_tsp_pkg::PH_ESC_IN;
        end else if (in_byte == osc_tsp_pkg::BYTE_BEL ||
                     (in_byte == osc_tsp_pkg::BYTE_ST8 && c1)) begin
          done = 1'b1;
        end else begin
          st = store_fn(st, in_byte);
          if (st.emit && k < 2'd3) begin
            slot[k] = '{title_byte: in_byte, title_end: 1'b0, title_command: st.cmd};
            k       = k + 2'd1;
          end
          done = (st.cnt >= Lim);
        end
      end
      osc_tsp_pkg::PH_ESC_IN: begin
        if (in_byte == osc_tsp_pkg::BYTE_BSLSH) begin
          done = 1'b1;
        end else begin
          st = store_fn(st, osc_tsp_pkg::BYTE_ESC);
          if (st.emit && k < 2'd3) begin
            slot[k] = '{title_byte: osc_tsp_pkg::BYTE_ESC, title_end: 1'b0,
                        title_command: st.cmd};
            k       = k + 2'd1;
          end
          st = store_fn(st, in_byte);
          if (st.emit && k < 2'd3) begin
            slot[k] = '{title_byte: in_byte, title_end: 1'b0, title_command: st.cmd};
            k       = k + 2'd1;
          end
          done = (st.cnt >= Lim);
          if (!done) begin
            phase_next = osc_tsp_pkg::PH_OSC;
          end
        end
      end
      default: begin
        phase_next = osc_tsp_pkg::PH_IDLE;
      end
    endcase
    if (done) begin
      if (st.fld == osc_tsp_pkg::FLD_TEXT && st.cmd <= 2'd2 && k < 2'd3) begin
        slot[k] = '{title_byte: 8'h00, title_end: 1'b1, title_command: st.cmd};
        k       = k + 2'd1;
      end
      phase_next = osc_tsp_pkg::PH_IDLE;
      st         = '{fld: osc_tsp_pkg::FLD_DIGITS, cmd: 2'd0, digit: 1'b0,
                     zero: 1'b0, cnt: '0, emit: 1'b0};
    end
    end_pend_next = (k == 2'd3);
  end

  assign push.p0 = fire && (k >= 2'd1);
  assign push.p1 = fire && (k >= 2'd2);
  assign push.i0 = slot[0];
  assign push.i1 = slot[1];

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
    if (fire && end_pend_next) begin
      pend_cmd <= slot[2].title_command;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1       <= 1'b0;
      in_vld   <= 1'b0;
      phase    <= osc_tsp_pkg::PH_IDLE;
      fld      <= osc_tsp_pkg::FLD_DIGITS;
      cmd      <= 2'd0;
      digit    <= 1'b0;
      zero     <= 1'b0;
      cnt      <= '0;
      end_pend <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        c1 <= cfg_wr_data;
      end
      if (s_tvalid && s_tready) begin
        in_vld <= 1'b1;
      end else if (fire) begin
        in_vld <= 1'b0;
      end
      if (fire) begin
        phase    <= phase_next;
        fld      <= st.fld;
        cmd      <= st.cmd;
        digit    <= st.digit;
        zero     <= st.zero;
        cnt      <= st.cnt[CW-1:0];
        end_pend <= end_pend_next;
      end
    end
  end

  `ASSERT_CLK(a_pend_idle, clk, rst, end_pend |-> (phase == osc_tsp_pkg::PH_IDLE),
              "held end beat outside idle")
  `ASSERT_NEVER(a_cnt_limit, clk, rst, {1'b0, cnt} >= Lim, "payload count past limit")
  `ASSERT_CLK(a_text_digit, clk, rst, (fld == osc_tsp_pkg::FLD_TEXT) |-> digit,
              "text phase without a command digit")

endmodule

// File: rtl/core/osc_title_sequence_parser.sv
// ----------------------------------------------------------------------------
// OSC title sequence parser
// Scans a terminal byte stream for OSC 0/1/2 sequences and streams the
// title bytes, each title closed by an end beat on tlast.
// ----------------------------------------------------------------------------
// A byte accepted on s_tready is held in the input register and parsed; its result beats
// are written into the result queue, whose count register raises m_tvalid.
// Throughput: one byte per cycle; escape pairs give two beats into a four-entry queue,
// and s_tready drops while a byte waits and fewer than two entries are free.
// Reset (synchronous, rst high) returns the parser to idle, empties the queue
// and clears accept_c1_controls.
module osc_title_sequence_parser #(
  parameter int unsigned BUF_SIZE = osc_tsp_pkg::BUF_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // accept_c1_controls
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,       // [7:0] data_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,       // [7:0] title_byte
  output logic       m_tlast,       // title_end
  output logic [1:0] m_tuser        // [1:0] title_command
);

  osc_tsp_pkg::push_t push;
  logic               room;

  osc_tsp_core #(
    .BUF_SIZE(BUF_SIZE)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .room       (room),
    .push       (push)
  );

  osc_tsp_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

endmodule
